>>> src/mfhd_pkg.sv
// Shared types, field codes and constant lookup tables for the MPEG audio
// Layer III frame header decoder. No dependencies.
package mfhd_pkg;

    // Header field codes
    localparam logic [10:0] SYNC_PATTERN      = 11'h7FF;
    localparam logic [1:0]  VER_BITS_MPEG25   = 2'b00;
    localparam logic [1:0]  VER_BITS_RESERVED = 2'b01;
    localparam logic [1:0]  VER_BITS_MPEG2    = 2'b10;
    localparam logic [1:0]  VER_BITS_MPEG1    = 2'b11;
    localparam logic [1:0]  LAYER_III         = 2'b01;
    localparam logic [3:0]  BR_IDX_FREE       = 4'd0;
    localparam logic [3:0]  BR_IDX_BAD        = 4'd15;
    localparam logic [1:0]  FS_IDX_BAD        = 2'd3;
    localparam logic [1:0]  MODE_MONO         = 2'd3;

    // Reported version codes (also the table row)
    localparam logic [1:0]  VER_MPEG2  = 2'd0;
    localparam logic [1:0]  VER_MPEG1  = 2'd1;
    localparam logic [1:0]  VER_MPEG25 = 2'd2;

    localparam logic [10:0] MAX_FRAME_LEN = 11'd1441;
    localparam logic [10:0] SAMPLES_LONG  = 11'd1152;
    localparam logic [10:0] SAMPLES_SHORT = 11'd576;
    localparam logic [1:0]  CHAN_MONO     = 2'd1;
    localparam logic [1:0]  CHAN_STEREO   = 2'd2;

    // Bitrate in kbit/s by [version][bitrate index]; free and bad index hold 0
    localparam logic [8:0] KBPS_TAB [0:2][0:15] = '{
        '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
          9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
        '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
          9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
        '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
          9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
    };

    // Sample rate in Hz by [version][rate index]
    localparam logic [15:0] FS_TAB [0:2][0:3] = '{
        '{16'd22050, 16'd24000, 16'd16000, 16'd0},
        '{16'd44100, 16'd48000, 16'd32000, 16'd0},
        '{16'd11025, 16'd12000, 16'd8000,  16'd0}
    };

    // Frame length without padding: floor(144000*kbps/fs), halved for the
    // half-rate versions. Indexed [version][rate index][bitrate index].
    localparam logic [10:0] LEN_TAB [0:2][0:3][0:15] = '{
        '{ // MPEG2
            '{11'd0, 11'd26, 11'd52, 11'd78, 11'd104, 11'd130, 11'd156, 11'd182,
              11'd208, 11'd261, 11'd313, 11'd365, 11'd417, 11'd470, 11'd522, 11'd0},
            '{11'd0, 11'd24, 11'd48, 11'd72, 11'd96, 11'd120, 11'd144, 11'd168,
              11'd192, 11'd240, 11'd288, 11'd336, 11'd384, 11'd432, 11'd480, 11'd0},
            '{11'd0, 11'd36, 11'd72, 11'd108, 11'd144, 11'd180, 11'd216, 11'd252,
              11'd288, 11'd360, 11'd432, 11'd504, 11'd576, 11'd648, 11'd720, 11'd0},
            '{16{11'd0}}
        },
        '{ // MPEG1
            '{11'd0, 11'd104, 11'd130, 11'd156, 11'd182, 11'd208, 11'd261, 11'd313,
              11'd365, 11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd1044, 11'd0},
            '{11'd0, 11'd96, 11'd120, 11'd144, 11'd168, 11'd192, 11'd240, 11'd288,
              11'd336, 11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd960, 11'd0},
            '{11'd0, 11'd144, 11'd180, 11'd216, 11'd252, 11'd288, 11'd360, 11'd432,
              11'd504, 11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1440, 11'd0},
            '{16{11'd0}}
        },
        '{ // MPEG2.5
            '{11'd0, 11'd52, 11'd104, 11'd156, 11'd208, 11'd261, 11'd313, 11'd365,
              11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd940, 11'd1044, 11'd0},
            '{11'd0, 11'd48, 11'd96, 11'd144, 11'd192, 11'd240, 11'd288, 11'd336,
              11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd864, 11'd960, 11'd0},
            '{11'd0, 11'd72, 11'd144, 11'd216, 11'd288, 11'd360, 11'd432, 11'd504,
              11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1296, 11'd1440, 11'd0},
            '{16{11'd0}}
        }
    };

    // Stage 1 -> stage 2
    typedef struct packed {
        logic       vld;
        logic       ok;
        logic [1:0] ver;
        logic [1:0] fs_idx;
        logic [3:0] br_idx;
        logic       pad;
        logic [1:0] mode;
    } parse_t;

    // Stage 2 -> stage 3
    typedef struct packed {
        logic        vld;
        logic        ok;
        logic        free;
        logic [1:0]  ver;
        logic [8:0]  kbps;
        logic [15:0] fs_hz;
        logic [10:0] len_base;
        logic        pad;
        logic [1:0]  mode;
    } lookup_t;

endpackage

>>> src/mfhd_parse.sv
// Stage 1: field extraction and header checks.
// Depends on mfhd_pkg.
module mfhd_parse (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            in_vld,
    input  logic [31:0]     header_word,
    input  logic            enough_bytes,
    output mfhd_pkg::parse_t parse_out
);

    mfhd_pkg::parse_t parse_reg;
    mfhd_pkg::parse_t parse_next;

    always_comb begin
        logic [1:0] ver_bits;
        logic       ver_ok;
        ver_bits = header_word[20:19];
        ver_ok   = 1'b1;
        parse_next.ver = mfhd_pkg::VER_MPEG2;
        unique case (ver_bits)
            mfhd_pkg::VER_BITS_MPEG25:   parse_next.ver = mfhd_pkg::VER_MPEG25;
            mfhd_pkg::VER_BITS_MPEG2:    parse_next.ver = mfhd_pkg::VER_MPEG2;
            mfhd_pkg::VER_BITS_MPEG1:    parse_next.ver = mfhd_pkg::VER_MPEG1;
            mfhd_pkg::VER_BITS_RESERVED: ver_ok = 1'b0;
            default:                     ver_ok = 1'b0;
        endcase
        parse_next.vld    = in_vld;
        parse_next.fs_idx = header_word[11:10];
        parse_next.br_idx = header_word[15:12];
        parse_next.pad    = header_word[9];
        parse_next.mode   = header_word[7:6];
        parse_next.ok     = enough_bytes
                          && (header_word[31:21] == mfhd_pkg::SYNC_PATTERN)
                          && ver_ok
                          && (header_word[18:17] == mfhd_pkg::LAYER_III)
                          && (header_word[15:12] != mfhd_pkg::BR_IDX_BAD)
                          && (header_word[11:10] != mfhd_pkg::FS_IDX_BAD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parse_reg.vld <= 1'b0;
        end else if (advance) begin
            parse_reg <= parse_next;
        end
    end

    assign parse_out = parse_reg;

endmodule

>>> src/mfhd_lookup.sv
// Stage 2: bitrate, sample rate and frame length table lookups.
// Depends on mfhd_pkg.
module mfhd_lookup (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  mfhd_pkg::parse_t  parse_in,
    output mfhd_pkg::lookup_t lookup_out
);

    mfhd_pkg::lookup_t lookup_reg;
    mfhd_pkg::lookup_t lookup_next;

    always_comb begin
        lookup_next.vld      = parse_in.vld;
        lookup_next.ok       = parse_in.ok;
        lookup_next.free     = (parse_in.br_idx == mfhd_pkg::BR_IDX_FREE);
        lookup_next.ver      = parse_in.ver;
        lookup_next.kbps     = mfhd_pkg::KBPS_TAB[parse_in.ver][parse_in.br_idx];
        lookup_next.fs_hz    = mfhd_pkg::FS_TAB[parse_in.ver][parse_in.fs_idx];
        lookup_next.len_base =
            mfhd_pkg::LEN_TAB[parse_in.ver][parse_in.fs_idx][parse_in.br_idx];
        lookup_next.pad      = parse_in.pad;
        lookup_next.mode     = parse_in.mode;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lookup_reg.vld <= 1'b0;
        end else if (advance) begin
            lookup_reg <= lookup_next;
        end
    end

    assign lookup_out = lookup_reg;

endmodule

>>> src/mfhd_format.sv
// Stage 3: frame length finish, result zeroing and output register.
// Depends on mfhd_pkg.
module mfhd_format (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  mfhd_pkg::lookup_t lookup_in,
    output logic              out_vld,
    output logic              valid_res,
    output logic [10:0]       frame_length,
    output logic              free_format,
    output logic [8:0]        bitrate_kbps,
    output logic [15:0]       sample_rate_hz,
    output logic [1:0]        version_id,
    output logic [10:0]       frame_samples,
    output logic [1:0]        channel_mode,
    output logic [1:0]        channel_count,
    output logic              padding_bit
);

    logic        out_vld_reg;
    logic        valid_res_reg,      valid_res_next;
    logic [10:0] frame_length_reg,   frame_length_next;
    logic        free_format_reg,    free_format_next;
    logic [8:0]  bitrate_kbps_reg,   bitrate_kbps_next;
    logic [15:0] sample_rate_hz_reg, sample_rate_hz_next;
    logic [1:0]  version_id_reg,     version_id_next;
    logic [10:0] frame_samples_reg,  frame_samples_next;
    logic [1:0]  channel_mode_reg,   channel_mode_next;
    logic [1:0]  channel_count_reg,  channel_count_next;
    logic        padding_bit_reg,    padding_bit_next;

    always_comb begin
        valid_res_next      = 1'b0;
        frame_length_next   = '0;
        free_format_next    = 1'b0;
        bitrate_kbps_next   = '0;
        sample_rate_hz_next = '0;
        version_id_next     = '0;
        frame_samples_next  = '0;
        channel_mode_next   = '0;
        channel_count_next  = '0;
        padding_bit_next    = 1'b0;
        if (lookup_in.ok) begin
            valid_res_next      = 1'b1;
            // free format: max length, padding not added
            frame_length_next   = lookup_in.free ? mfhd_pkg::MAX_FRAME_LEN
                                : lookup_in.len_base + {10'd0, lookup_in.pad};
            free_format_next    = lookup_in.free;
            bitrate_kbps_next   = lookup_in.kbps;
            sample_rate_hz_next = lookup_in.fs_hz;
            version_id_next     = lookup_in.ver;
            frame_samples_next  = (lookup_in.ver == mfhd_pkg::VER_MPEG1)
                                ? mfhd_pkg::SAMPLES_LONG : mfhd_pkg::SAMPLES_SHORT;
            channel_mode_next   = lookup_in.mode;
            channel_count_next  = (lookup_in.mode == mfhd_pkg::MODE_MONO)
                                ? mfhd_pkg::CHAN_MONO : mfhd_pkg::CHAN_STEREO;
            padding_bit_next    = lookup_in.pad;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg        <= lookup_in.vld;
            valid_res_reg      <= valid_res_next;
            frame_length_reg   <= frame_length_next;
            free_format_reg    <= free_format_next;
            bitrate_kbps_reg   <= bitrate_kbps_next;
            sample_rate_hz_reg <= sample_rate_hz_next;
            version_id_reg     <= version_id_next;
            frame_samples_reg  <= frame_samples_next;
            channel_mode_reg   <= channel_mode_next;
            channel_count_reg  <= channel_count_next;
            padding_bit_reg    <= padding_bit_next;
        end
    end

    assign out_vld        = out_vld_reg;
    assign valid_res      = valid_res_reg;
    assign frame_length   = frame_length_reg;
    assign free_format    = free_format_reg;
    assign bitrate_kbps   = bitrate_kbps_reg;
    assign sample_rate_hz = sample_rate_hz_reg;
    assign version_id     = version_id_reg;
    assign frame_samples  = frame_samples_reg;
    assign channel_mode   = channel_mode_reg;
    assign channel_count  = channel_count_reg;
    assign padding_bit    = padding_bit_reg;

endmodule

>>> src/mp3_frame_header_decode_unit.sv
// Top level of the MPEG audio Layer III frame header decoder.
// Depends on mfhd_pkg, mfhd_parse, mfhd_lookup and mfhd_format.
//
// s_ channel: one 32-bit header word (first stream byte in bits 31..24)
//   plus s_enough_bytes per item, valid/ready handshake.
// m_ channel: one decoded result per input item, in order, valid/ready.
//   A failed check (sync, reserved version, non-Layer-III, bitrate index
//   15, rate index 3, too few bytes) gives m_valid_res = 0 and every other
//   field zero. Free format reports the maximum frame length of 1441 bytes.
// Timing: three register stages (parse/check, table lookup, format/output).
//   An accepted item moves through the parse, lookup and output registers
//   in turn. One item per cycle is sustained while m_ready stays high; the
//   frame length is a constant table lookup, so there is no divider.
// Reset: aresetn (synchronous, active low) clears the stage valid bits only;
//   the data registers are not reset.
// Stall: while m_valid is high and m_ready low the whole pipeline freezes
//   and s_ready drops; nothing is dropped or repeated, and empty stages do
//   not fill until the output register is taken.
module mp3_frame_header_decode_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_header_word,
    input  logic        s_enough_bytes,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_valid_res,
    output logic [10:0] m_frame_length,
    output logic        m_free_format,
    output logic [8:0]  m_bitrate_kbps,
    output logic [15:0] m_sample_rate_hz,
    output logic [1:0]  m_version_id,
    output logic [10:0] m_frame_samples,
    output logic [1:0]  m_channel_mode,
    output logic [1:0]  m_channel_count,
    output logic        m_padding_bit
);

    mfhd_pkg::parse_t  parse_bus;
    mfhd_pkg::lookup_t lookup_bus;
    logic              advance;

    // Whole pipeline moves when the output register is free or being taken
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    mfhd_parse u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .in_vld       (s_valid),
        .header_word  (s_header_word),
        .enough_bytes (s_enough_bytes),
        .parse_out    (parse_bus)
    );

    mfhd_lookup u_lookup (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .parse_in   (parse_bus),
        .lookup_out (lookup_bus)
    );

    mfhd_format u_format (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .lookup_in      (lookup_bus),
        .out_vld        (m_valid),
        .valid_res      (m_valid_res),
        .frame_length   (m_frame_length),
        .free_format    (m_free_format),
        .bitrate_kbps   (m_bitrate_kbps),
        .sample_rate_hz (m_sample_rate_hz),
        .version_id     (m_version_id),
        .frame_samples  (m_frame_samples),
        .channel_mode   (m_channel_mode),
        .channel_count  (m_channel_count),
        .padding_bit    (m_padding_bit)
    );

    // Rejected headers carry all-zero fields
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_valid_res) |-> (m_frame_length == 11'd0
            && m_bitrate_kbps == 9'd0 && m_sample_rate_hz == 16'd0
            && m_frame_samples == 11'd0 && m_channel_count == 2'd0))
        else $error("rejected header with nonzero fields");

    // Accepted headers have a sane length and rate
    a_accept_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_valid_res) |-> (m_frame_length != 11'd0
            && m_frame_length <= mfhd_pkg::MAX_FRAME_LEN
            && m_sample_rate_hz != 16'd0))
        else $error("accepted header with bad length or rate");

    // Table bitrate present exactly when not free format
    a_free_kbps: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_valid_res) |-> ((m_bitrate_kbps == 9'd0) == m_free_format))
        else $error("bitrate and free-format flag disagree");

    // Long frames only for MPEG1
    a_samples_ver: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_valid_res) |->
            ((m_frame_samples == mfhd_pkg::SAMPLES_LONG)
             == (m_version_id == mfhd_pkg::VER_MPEG1)))
        else $error("frame samples do not match version");

endmodule
